/* rtl/core/cft_pkg.sv */
package cft_pkg;

    localparam int ENTRIES     = 64;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int FILL_W      = $clog2(ENTRIES + 1);
    localparam int COUNT_BITS  = 16;
    localparam int CODE_BITS   = 32;
    localparam int CMD_BITS    = 3;
    localparam int STATUS_BITS = 2;

    localparam logic [CMD_BITS-1:0] CMD_REPORT    = 3'd0;
    localparam logic [CMD_BITS-1:0] CMD_QUERY     = 3'd1;
    localparam logic [CMD_BITS-1:0] CMD_TAKE      = 3'd2;
    localparam logic [CMD_BITS-1:0] CMD_CLR_MARKS = 3'd3;
    localparam logic [CMD_BITS-1:0] CMD_CLR_TABLE = 3'd4;

    localparam logic [STATUS_BITS-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL      = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_NONE      = 2'd3;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef logic [IDX_W-1:0]      idx_t;
    typedef logic [FILL_W-1:0]     fill_t;
    typedef logic [COUNT_BITS-1:0] count_t;
    typedef logic [CODE_BITS-1:0]  code_t;

    typedef struct packed {
        logic [CMD_BITS-1:0] cmd;
        code_t               code_in;
    } cft_item_t;

    typedef struct packed {
        logic [STATUS_BITS-1:0] status;
        count_t                 count_out;
        code_t                  code_out;
    } cft_result_t;

    typedef struct packed {
        logic   rd_en;
        idx_t   rd_addr;
        logic   wr_en;
        logic   taken_wr_en;
        idx_t   wr_addr;
        code_t  wr_code;
        count_t wr_count;
        logic   wr_taken;
    } cft_ram_req_t;

    typedef struct packed {
        code_t  code;
        count_t count;
        logic   taken;
    } cft_ram_rsp_t;

endpackage

/* rtl/core/cft_cmd_if.sv */
interface cft_cmd_if;
    import cft_pkg::*;

    logic                valid;
    logic                ready;
    logic [CMD_BITS-1:0] cmd;
    code_t               code_in;

    modport source (output valid, output cmd, output code_in, input ready);
    modport sink   (input valid, input cmd, input code_in, output ready);
endinterface

/* rtl/core/cft_res_if.sv */
interface cft_res_if;
    import cft_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [STATUS_BITS-1:0] status;
    count_t                 count_out;
    code_t                  code_out;

    modport source (output valid, output status, output count_out, output code_out,
                    input ready);
    modport sink   (input valid, input status, input count_out, input code_out,
                    output ready);
endinterface

/* rtl/core/code_frequency_table.sv */
// one command at a time; report, query and take-most scan the used entries with one
// memory read per cycle; report and query finish early when the code is found early
// in the table, while take-most always scans all used entries
// clear marks walks the used entries; clear table and unused codes finish without a scan
// the next command transfers once the previous result has moved into the output register
// reset empties the table at once; entry contents are not cleared and need no sweep
module code_frequency_table (
    input  logic      clk,
    input  logic      rst_n,
    cft_cmd_if.sink   cmd_ch,
    cft_res_if.source res_ch
);
    import cft_pkg::*;

    cft_item_t    item;
    cft_result_t  eng_res;
    logic         eng_ready;
    logic         eng_done;
    logic         res_take;
    cft_ram_req_t ram_req;
    cft_ram_rsp_t ram_rsp;

    logic         out_valid_reg, out_valid_next;
    cft_result_t  out_reg;

    assign item.cmd     = cmd_ch.cmd;
    assign item.code_in = cmd_ch.code_in;
    assign cmd_ch.ready = eng_ready;

    cft_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd_ch.valid),
        .in_ready  (eng_ready),
        .in_item   (item),
        .res_valid (eng_done),
        .res_take  (res_take),
        .res       (eng_res),
        .ram_req   (ram_req),
        .ram_rsp   (ram_rsp)
    );

    cft_ram u_ram (
        .clk (clk),
        .req (ram_req),
        .rsp (ram_rsp)
    );

    // output register is free when empty or draining in this cycle
    assign res_take = eng_done && (!out_valid_reg || res_ch.ready);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_take)
        begin
            out_valid_next = 1'b1;
        end
        else if (res_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            out_reg <= eng_res;
        end
    end

    assign res_ch.valid     = out_valid_reg;
    assign res_ch.status    = out_reg.status;
    assign res_ch.count_out = out_reg.count_out;
    assign res_ch.code_out  = out_reg.code_out;
endmodule

/* rtl/core/cft_ram.sv */
module cft_ram (
    input  logic                  clk,
    input  cft_pkg::cft_ram_req_t req,
    output cft_pkg::cft_ram_rsp_t rsp
);
    import cft_pkg::*;

    code_t        code_mem  [ENTRIES];
    count_t       count_mem [ENTRIES];
    logic         taken_mem [ENTRIES];
    cft_ram_rsp_t rsp_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            code_mem[req.wr_addr]  <= req.wr_code;
            count_mem[req.wr_addr] <= req.wr_count;
        end
        if (req.taken_wr_en)
        begin
            taken_mem[req.wr_addr] <= req.wr_taken;
        end
        if (req.rd_en)
        begin
            rsp_reg.code  <= code_mem[req.rd_addr];
            rsp_reg.count <= count_mem[req.rd_addr];
            rsp_reg.taken <= taken_mem[req.rd_addr];
        end
    end

    assign rsp = rsp_reg;
endmodule

/* rtl/core/cft_engine.sv */
module cft_engine (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  cft_pkg::cft_item_t    in_item,
    output logic                  res_valid,
    input  logic                  res_take,
    output cft_pkg::cft_result_t  res,
    output cft_pkg::cft_ram_req_t ram_req,
    input  cft_pkg::cft_ram_rsp_t ram_rsp
);
    import cft_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_CLR  = 3'd2;
    localparam logic [2:0] S_WB   = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    logic [2:0]          state_reg,      state_next;
    fill_t               fill_reg,       fill_next;
    fill_t               scan_reg,       scan_next;
    logic                pend_reg,       pend_next;
    logic                best_valid_reg, best_valid_next;

    logic [CMD_BITS-1:0] cmd_reg,        cmd_next;
    code_t               code_reg,       code_next;
    idx_t                cmp_idx_reg,    cmp_idx_next;
    count_t              best_count_reg, best_count_next;
    idx_t                best_idx_reg,   best_idx_next;
    code_t               best_code_reg,  best_code_next;
    logic                wb_we_reg,      wb_we_next;
    logic                wb_tk_we_reg,   wb_tk_we_next;
    idx_t                wb_addr_reg,    wb_addr_next;
    code_t               wb_code_reg,    wb_code_next;
    count_t              wb_count_reg,   wb_count_next;
    logic                wb_taken_reg,   wb_taken_next;
    cft_result_t         res_reg,        res_next;

    logic                scan_end;
    logic                hit;
    count_t              inc_count;

    assign scan_end  = !pend_reg && (scan_reg >= fill_reg);
    assign hit       = pend_reg && (ram_rsp.code == code_reg);
    assign inc_count = (ram_rsp.count == COUNT_MAX) ? ram_rsp.count
                                                    : ram_rsp.count + 1'b1;

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        scan_next       = scan_reg;
        pend_next       = pend_reg;
        best_valid_next = best_valid_reg;
        cmd_next        = cmd_reg;
        code_next       = code_reg;
        cmp_idx_next    = cmp_idx_reg;
        best_count_next = best_count_reg;
        best_idx_next   = best_idx_reg;
        best_code_next  = best_code_reg;
        wb_we_next      = wb_we_reg;
        wb_tk_we_next   = wb_tk_we_reg;
        wb_addr_next    = wb_addr_reg;
        wb_code_next    = wb_code_reg;
        wb_count_next   = wb_count_reg;
        wb_taken_next   = wb_taken_reg;
        res_next        = res_reg;

        ram_req             = '0;
        ram_req.rd_addr     = scan_reg[IDX_W-1:0];
        ram_req.wr_addr     = wb_addr_reg;
        ram_req.wr_code     = wb_code_reg;
        ram_req.wr_count    = wb_count_reg;
        ram_req.wr_taken    = wb_taken_reg;

        in_ready  = (state_reg == S_IDLE);
        res_valid = (state_reg == S_DONE);

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd_next        = in_item.cmd;
                    code_next       = in_item.code_in;
                    scan_next       = '0;
                    pend_next       = 1'b0;
                    best_valid_next = 1'b0;
                    best_count_next = '0;
                    wb_we_next      = 1'b0;
                    wb_tk_we_next   = 1'b0;
                    res_next        = '{status: ST_OK, count_out: '0, code_out: '0};
                    case (in_item.cmd) inside
                        CMD_REPORT, CMD_QUERY, CMD_TAKE: state_next = S_SCAN;
                        CMD_CLR_MARKS:                   state_next = S_CLR;
                        CMD_CLR_TABLE:
                        begin
                            fill_next  = '0;
                            state_next = S_DONE;
                        end
                        default:                         state_next = S_DONE;
                    endcase
                end
            end

            S_SCAN:
            begin
                // one read issued per cycle, data compared in the following cycle
                if (scan_reg < fill_reg)
                begin
                    ram_req.rd_en = 1'b1;
                    scan_next     = scan_reg + 1'b1;
                    pend_next     = 1'b1;
                    cmp_idx_next  = scan_reg[IDX_W-1:0];
                end
                else
                begin
                    pend_next = 1'b0;
                end

                if (cmd_reg == CMD_TAKE)
                begin
                    if (pend_reg && !ram_rsp.taken && (ram_rsp.count > best_count_reg))
                    begin
                        best_valid_next = 1'b1;
                        best_count_next = ram_rsp.count;
                        best_idx_next   = cmp_idx_reg;
                        best_code_next  = ram_rsp.code;
                    end
                    if (scan_end)
                    begin
                        if (best_valid_reg)
                        begin
                            wb_tk_we_next = 1'b1;
                            wb_addr_next  = best_idx_reg;
                            wb_taken_next = 1'b1;
                            res_next      = '{status: ST_OK, count_out: best_count_reg,
                                              code_out: best_code_reg};
                        end
                        else
                        begin
                            res_next.status = ST_NONE;
                        end
                        state_next = S_WB;
                    end
                end
                else if (hit)
                begin
                    if (cmd_reg == CMD_QUERY)
                    begin
                        res_next.count_out = ram_rsp.count;
                        state_next         = S_DONE;
                    end
                    else
                    begin
                        wb_we_next         = 1'b1;
                        wb_addr_next       = cmp_idx_reg;
                        wb_code_next       = code_reg;
                        wb_count_next      = inc_count;
                        res_next.count_out = inc_count;
                        state_next         = S_WB;
                    end
                end
                else if (scan_end)
                begin
                    if (cmd_reg == CMD_QUERY)
                    begin
                        res_next.status = ST_NOT_FOUND;
                        state_next      = S_DONE;
                    end
                    else if (fill_reg == fill_t'(ENTRIES))
                    begin
                        res_next.status = ST_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // append new code with a single occurrence, mark clear
                        wb_we_next         = 1'b1;
                        wb_tk_we_next      = 1'b1;
                        wb_addr_next       = fill_reg[IDX_W-1:0];
                        wb_code_next       = code_reg;
                        wb_count_next      = count_t'(1);
                        wb_taken_next      = 1'b0;
                        fill_next          = fill_reg + 1'b1;
                        res_next.count_out = count_t'(1);
                        state_next         = S_WB;
                    end
                end
            end

            S_CLR:
            begin
                if (scan_reg < fill_reg)
                begin
                    ram_req.taken_wr_en = 1'b1;
                    ram_req.wr_addr     = scan_reg[IDX_W-1:0];
                    ram_req.wr_taken    = 1'b0;
                    scan_next           = scan_reg + 1'b1;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end

            S_WB:
            begin
                ram_req.wr_en       = wb_we_reg;
                ram_req.taken_wr_en = wb_tk_we_reg;
                state_next          = S_DONE;
            end

            S_DONE:
            begin
                if (res_take)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fill_reg       <= '0;
            scan_reg       <= '0;
            pend_reg       <= 1'b0;
            best_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            scan_reg       <= scan_next;
            pend_reg       <= pend_next;
            best_valid_reg <= best_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        code_reg       <= code_next;
        cmp_idx_reg    <= cmp_idx_next;
        best_count_reg <= best_count_next;
        best_idx_reg   <= best_idx_next;
        best_code_reg  <= best_code_next;
        wb_we_reg      <= wb_we_next;
        wb_tk_we_reg   <= wb_tk_we_next;
        wb_addr_reg    <= wb_addr_next;
        wb_code_reg    <= wb_code_next;
        wb_count_reg   <= wb_count_next;
        wb_taken_reg   <= wb_taken_next;
        res_reg        <= res_next;
    end

    assign res = res_reg;
endmodule

/* tb/testbench.sv */
module testbench;
    import cft_pkg::*;

    localparam int POOL_SIZE      = 80;
    localparam int PHASE_ITEMS    = 400;
    localparam int RUN_ITEMS      = 100;
    localparam int DRAIN_CYCLES   = 80;
    localparam int MAX_GAP        = 20;
    localparam int TIMEOUT_CYCLES = 3_000_000;

    // command codes the block treats as no-ops
    localparam logic [CMD_BITS-1:0] CMD_SPARE_5 = 3'd5;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_6 = 3'd6;
    localparam logic [CMD_BITS-1:0] CMD_SPARE_7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n;

    cft_cmd_if cmd_ch ();
    cft_res_if res_ch ();

    code_frequency_table u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd_ch (cmd_ch),
        .res_ch (res_ch)
    );

    // shadow copy of the frequency table
    code_t       tbl_code  [ENTRIES];
    count_t      tbl_count [ENTRIES];
    logic        tbl_taken [ENTRIES];
    int          tbl_fill = 0;

    cft_result_t pending_results [$];
    cft_result_t oldest_result;
    code_t       code_pool [POOL_SIZE];
    int          error_count   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic int find_code(input code_t code);
        for (int i = 0; i < tbl_fill; i++)
        begin
            if (tbl_code[i] == code)
                return i;
        end
        return -1;
    endfunction

    function automatic cft_result_t apply_to_table(input logic [CMD_BITS-1:0] c,
                                                   input code_t code);
        cft_result_t r;
        int          hit;
        int          best_idx;
        count_t      best;
        r        = '0;
        r.status = ST_OK;
        case (c)
            CMD_REPORT:
            begin
                hit = find_code(code);
                if (hit >= 0)
                begin
                    if (tbl_count[hit] != COUNT_MAX)
                        tbl_count[hit]++;
                    r.count_out = tbl_count[hit];
                end
                else if (tbl_fill >= ENTRIES)
                    r.status = ST_FULL;
                else
                begin
                    tbl_code[tbl_fill]  = code;
                    tbl_count[tbl_fill] = count_t'(1);
                    tbl_taken[tbl_fill] = 1'b0;
                    tbl_fill++;
                    r.count_out = count_t'(1);
                end
            end
            CMD_QUERY:
            begin
                hit = find_code(code);
                if (hit >= 0)
                    r.count_out = tbl_count[hit];
                else
                    r.status = ST_NOT_FOUND;
            end
            CMD_TAKE:
            begin
                best     = '0;
                best_idx = -1;
                // strict compare keeps the lowest index on ties
                for (int i = 0; i < tbl_fill; i++)
                begin
                    if (!tbl_taken[i] && tbl_count[i] > best)
                    begin
                        best     = tbl_count[i];
                        best_idx = i;
                    end
                end
                if (best_idx >= 0)
                begin
                    tbl_taken[best_idx] = 1'b1;
                    r.count_out         = best;
                    r.code_out          = tbl_code[best_idx];
                end
                else
                    r.status = ST_NONE;
            end
            CMD_CLR_MARKS:
            begin
                for (int i = 0; i < tbl_fill; i++)
                    tbl_taken[i] = 1'b0;
            end
            CMD_CLR_TABLE:
                tbl_fill = 0;
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic send_cmd(input logic [CMD_BITS-1:0] c, input code_t code);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_ch.valid   <= 1'b1;
        cmd_ch.cmd     <= c;
        cmd_ch.code_in <= code;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        pending_results.push_back(apply_to_table(c, code));
    endtask

    task automatic set_idling(input int idle, input int stall);
        send_idle_pct = idle;
        stall_pct     = stall;
    endtask

    task automatic test_basic;
        set_idling(30, 30);
        send_cmd(CMD_CLR_TABLE, 32'h0);
        send_cmd(CMD_QUERY, 32'h0);
        send_cmd(CMD_TAKE, 32'h0);
        send_cmd(CMD_REPORT, 32'hFFFF_FFFF);
        send_cmd(CMD_REPORT, 32'h0000_0000);
        send_cmd(CMD_REPORT, 32'h0000_0000);
        send_cmd(CMD_REPORT, 32'hA5A5_5A5A);
        send_cmd(CMD_REPORT, 32'hFFFF_FFFF);
        send_cmd(CMD_QUERY, 32'h0000_0000);
        send_cmd(CMD_QUERY, 32'h0000_1234);
        // two entries tie at count 2, index 0 first
        send_cmd(CMD_TAKE, $urandom);
        send_cmd(CMD_TAKE, $urandom);
        send_cmd(CMD_TAKE, $urandom);
        send_cmd(CMD_TAKE, $urandom);
        send_cmd(CMD_CLR_MARKS, $urandom);
        send_cmd(CMD_TAKE, $urandom);
        send_cmd(CMD_SPARE_5, $urandom);
        send_cmd(CMD_SPARE_6, $urandom);
        send_cmd(CMD_SPARE_7, $urandom);
        send_cmd(CMD_CLR_TABLE, $urandom);
        send_cmd(CMD_QUERY, 32'hFFFF_FFFF);
        send_cmd(CMD_TAKE, $urandom);
        send_cmd(CMD_REPORT, 32'h8000_0001);
    endtask

    task automatic test_table_full;
        set_idling(30, 30);
        send_cmd(CMD_CLR_TABLE, 32'h0);
        for (int i = 0; i < ENTRIES; i++)
            send_cmd(CMD_REPORT, 32'hC0DE_0000 + i);
        send_cmd(CMD_REPORT, 32'hDEAD_BEEF);
        send_cmd(CMD_REPORT, 32'hC0DE_0005);
        send_cmd(CMD_QUERY, 32'hDEAD_BEEF);
        send_cmd(CMD_TAKE, 32'h0);
        send_cmd(CMD_TAKE, 32'h0);
        send_cmd(CMD_CLR_MARKS, 32'h0);
    endtask

    task automatic test_long_count;
        set_idling(0, 0);
        send_cmd(CMD_CLR_TABLE, 32'h0);
        // a long run of reports on one code
        for (int i = 0; i < RUN_ITEMS; i++)
            send_cmd(CMD_REPORT, 32'h5A5A_0F0F);
        send_cmd(CMD_QUERY, 32'h5A5A_0F0F);
        send_cmd(CMD_TAKE, 32'h0);
    endtask

    task automatic test_random_phase(input int idle, input int stall);
        int                  roll;
        logic [CMD_BITS-1:0] c;
        code_t               code;
        set_idling(idle, stall);
        for (int n = 0; n < PHASE_ITEMS; n++)
        begin
            roll = $urandom_range(0, 999);
            if (roll < 5)
                c = CMD_CLR_TABLE;
            else if (roll < 500)
                c = CMD_REPORT;
            else if (roll < 700)
                c = CMD_QUERY;
            else if (roll < 850)
                c = CMD_TAKE;
            else if (roll < 930)
                c = CMD_CLR_MARKS;
            else if (roll < 960)
            begin
                case ($urandom_range(0, 2))
                    0:       c = CMD_SPARE_5;
                    1:       c = CMD_SPARE_6;
                    default: c = CMD_SPARE_7;
                endcase
            end
            else
                c = CMD_REPORT;
            // mostly repeat codes so lookups hit and the table fills up
            if ($urandom_range(0, 99) < 88)
                code = code_pool[$urandom_range(0, POOL_SIZE - 1)];
            else
                code = $urandom;
            send_cmd(c, code);
        end
    endtask

    task automatic test_random;
        code_pool[0] = 32'h0000_0000;
        code_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            code_pool[i] = $urandom;
        test_random_phase(0, 0);
        test_random_phase(55, 0);
        test_random_phase(0, 55);
        test_random_phase(30, 30);
    endtask

    task automatic drain;
        cmd_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver side: random back-pressure
    always @(posedge clk)
        res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result transfer with nothing pending", res_ch.code_out, 32'h0);
            else
            begin
                oldest_result = pending_results.pop_front();
                if (res_ch.status !== oldest_result.status)
                    report_mismatch("status", 32'(res_ch.status),
                                    32'(oldest_result.status));
                if (res_ch.count_out !== oldest_result.count_out)
                    report_mismatch("count_out", 32'(res_ch.count_out),
                                    32'(oldest_result.count_out));
                if (res_ch.code_out !== oldest_result.code_out)
                    report_mismatch("code_out", res_ch.code_out, oldest_result.code_out);
            end
        end
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 10);
        $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        rst_n          = 1'b0;
        cmd_ch.valid   = 1'b0;
        cmd_ch.cmd     = CMD_REPORT;
        cmd_ch.code_in = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_basic;
        test_table_full;
        test_long_count;
        test_random;
        drain;

        if (pending_results.size() != 0)
        begin
            $display("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/cft_pkg.sv
rtl/core/cft_cmd_if.sv
rtl/core/cft_res_if.sv
rtl/core/cft_ram.sv
rtl/core/cft_engine.sv
rtl/core/code_frequency_table.sv
tb/testbench.sv
